@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/tmss_pkg.sv @@
// Package for the tiled matrix-product schedule sequencer.
// Holds field widths, operation codes, phase codes and shared types.
package tmss_pkg;

    localparam int M_W   = 24;
    localparam int N_W   = 16;
    localparam int K_W   = 24;
    localparam int TM_W  = 16;
    localparam int TN_W  = 12;
    localparam int TK_W  = 16;
    localparam int SEQ_W = 48;
    localparam int CFG_W = 24;
    localparam int IDX_W = 3;
    // Divider operand width covers the widest logical size.
    localparam int DIV_W = 24;

    typedef enum logic [2:0] {
        KIND_LOAD_INPUT   = 3'd0,
        KIND_LOAD_WEIGHT  = 3'd1,
        KIND_RELOAD       = 3'd2,
        KIND_COMPUTE      = 3'd3,
        KIND_STORE_PART   = 3'd4,
        KIND_STORE_FINAL  = 3'd5,
        KIND_SYNC         = 3'd6
    } kind_t;

    localparam logic [2:0] PH_0    = 3'd0;
    localparam logic [2:0] PH_1    = 3'd1;
    localparam logic [2:0] PH_2    = 3'd2;
    localparam logic [2:0] PH_3    = 3'd3;
    localparam logic [2:0] PH_4    = 3'd4;
    localparam logic [2:0] PH_5    = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd7;

    localparam logic [1:0] MODE_WS = 2'd0;
    localparam logic [1:0] MODE_IS = 2'd1;
    localparam logic [1:0] MODE_OS = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_LM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_LK   = 3'd3;
    localparam logic [IDX_W-1:0] REG_TM   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_TK   = 3'd6;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/tmss_ceil_div.sv @@
// Iterative restoring divider that returns the ceiling of a quotient; a zero divisor gives zero.
// Depends on tmss_pkg for widths and the request/response types.
module tmss_ceil_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tmss_pkg::div_req_t req,
    output tmss_pkg::div_rsp_t rsp
);

    localparam int W  = tmss_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    // One quotient bit per cycle, then a round-up step for a nonzero remainder.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CW'(W);
            busy_next = (req.divisor != '0);
            done_next = (req.divisor == '0);
            if (req.divisor == '0)
            begin
                quo_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                quo_next = {quo_reg[W-2:0], ~diff[W]};
                rem_next = diff[W] ? shifted : diff;
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                if (rem_reg != '0)
                begin
                    quo_next = quo_reg + 1'b1;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hdl/tiled_matmul_schedule_sequencer.sv @@
// Top level of the tiled matrix-product schedule sequencer.
// Depends on tmss_pkg and instantiates tmss_ceil_div.
//
//  channel  | valid / stall   | payload
//  ---------+-----------------+------------------------------------------
//  in       | in_valid/stall  | restart
//  out      | out_valid/stall | kind, indices, extents, flags, seq_number
//  config   | cfg_we          | cfg_index, cfg_data
//
// A request without restart passes through a state that chooses the operation, three
// extent multiplies (M, N, K) on the one shared multiplier and a state that holds the
// registered result, then returns to idle, where the next request is taken.
// A restart first runs three ceiling divisions (M, N, K) on the shared divider. A request
// that yields no operation goes from the choice straight back to idle.
// Reset clears the counts, indices, phase and sequence counter. A stalled
// result holds in the output register; no new request is taken until it leaves.
module tiled_matmul_schedule_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmss_pkg::IDX_W-1:0]       cfg_index,
    input  logic [tmss_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       kind,
    output logic [tmss_pkg::M_W-1:0]         m_index,
    output logic [tmss_pkg::N_W-1:0]         n_index,
    output logic [tmss_pkg::K_W-1:0]         k_index,
    output logic [tmss_pkg::TM_W-1:0]        valid_m,
    output logic [tmss_pkg::TN_W-1:0]        valid_n,
    output logic [tmss_pkg::TK_W-1:0]        valid_k,
    output logic                             boundary,
    output logic                             final_reduction,
    output logic [tmss_pkg::SEQ_W-1:0]       seq_number,
    output logic                             last_op
);

    localparam int M_W = tmss_pkg::M_W;
    localparam int N_W = tmss_pkg::N_W;
    localparam int K_W = tmss_pkg::K_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIVM  = 9'b000000010,
        ST_DIVN  = 9'b000000100,
        ST_DIVK  = 9'b000001000,
        ST_DECIDE= 9'b000010000,
        ST_EXTM  = 9'b000100000,
        ST_EXTN  = 9'b001000000,
        ST_EXTK  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0]       mode_reg;
    logic [M_W-1:0]   lm_reg;
    logic [N_W-1:0]   ln_reg;
    logic [K_W-1:0]   lk_reg;
    logic [15:0]      tm_reg;
    logic [11:0]      tn_reg;
    logic [15:0]      tk_reg;

    // Schedule state.
    logic [M_W-1:0]   cm_reg, cm_next;
    logic [N_W-1:0]   cn_reg, cn_next;
    logic [K_W-1:0]   ck_reg, ck_next;
    logic [M_W-1:0]   im_reg, im_next;
    logic [N_W-1:0]   in_reg, in_next;
    logic [K_W-1:0]   ik_reg, ik_next;
    logic [2:0]       ph_reg, ph_next;
    logic [47:0]      op_reg, op_next;

    // Snapshot of the operation being built.
    logic [2:0]       ok_reg, ok_next;
    logic [M_W-1:0]   om_reg, om_next;
    logic [N_W-1:0]   on_reg, on_next;
    logic [K_W-1:0]   okx_reg, okx_next;
    logic [15:0]      vm_reg, vm_next;
    logic [11:0]      vn_reg, vn_next;
    logic [15:0]      vk_reg, vk_next;
    logic             fr_reg, fr_next;
    logic             lst_reg, lst_next;
    logic             ov_reg, ov_next;

    tmss_pkg::div_req_t dreq;
    tmss_pkg::div_rsp_t drsp;

    tmss_ceil_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Shared multiplier: index times tile, one dimension per cycle.
    logic [M_W-1:0] mul_a;
    logic [15:0]    mul_b;
    logic [39:0]    prod;
    logic [39:0]    logic_sel;
    logic [15:0]    tile_sel;
    logic [39:0]    rem_full;
    logic [15:0]    ext;
    assign prod = mul_a * mul_b;

    always_comb
    begin
        rem_full = logic_sel - prod;
        if (prod >= logic_sel)
        begin
            ext = '0;
        end
        else if (rem_full < {24'd0, tile_sel})
        begin
            ext = rem_full[15:0];
        end
        else
        begin
            ext = tile_sel;
        end
    end

    always_comb
    begin
        mul_a     = im_reg;
        mul_b     = tm_reg;
        logic_sel = {16'd0, lm_reg};
        tile_sel  = tm_reg;
        case (state_reg)
            ST_EXTN:
            begin
                mul_a     = {8'd0, on_reg};
                mul_b     = {4'd0, tn_reg};
                logic_sel = {24'd0, ln_reg};
                tile_sel  = {4'd0, tn_reg};
            end
            ST_EXTK:
            begin
                mul_a     = okx_reg;
                mul_b     = tk_reg;
                logic_sel = {16'd0, lk_reg};
                tile_sel  = tk_reg;
            end
            default:
            begin
                mul_a     = om_reg;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Sequencer: divides on restart, then steps the loop nest.
    always_comb
    begin
        logic ok;
        logic [2:0] k;
        logic [M_W-1:0] nm;
        logic [N_W-1:0] nn;
        logic [K_W-1:0] nk;
        logic [2:0] np;
        logic inner_wrap;
        logic outer_wrap;
        logic k_wrap;
        state_next = state_reg;
        cm_next = cm_reg; cn_next = cn_reg; ck_next = ck_reg;
        im_next = im_reg; in_next = in_reg; ik_next = ik_reg;
        ph_next = ph_reg; op_next = op_reg;
        ok_next = ok_reg; om_next = om_reg; on_next = on_reg; okx_next = okx_reg;
        vm_next = vm_reg; vn_next = vn_reg; vk_next = vk_reg;
        fr_next = fr_reg; lst_next = lst_reg; ov_next = ov_reg;
        dreq = '0;
        ok = 1'b0; k = 3'd0; nm = im_reg; nn = in_reg; nk = ik_reg; np = ph_reg;
        inner_wrap = 1'b0; outer_wrap = 1'b0; k_wrap = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = lm_reg;
                        dreq.divisor  = {8'd0, tm_reg};
                        im_next = '0; in_next = '0; ik_next = '0;
                        ph_next = tmss_pkg::PH_0; op_next = '0;
                        state_next = ST_DIVM;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DIVM:
            begin
                if (drsp.done)
                begin
                    cm_next = drsp.quotient;
                    dreq.start    = 1'b1;
                    dreq.dividend = {8'd0, ln_reg};
                    dreq.divisor  = {12'd0, tn_reg};
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (drsp.done)
                begin
                    cn_next = drsp.quotient[N_W-1:0];
                    dreq.start    = 1'b1;
                    dreq.dividend = lk_reg;
                    dreq.divisor  = {8'd0, tk_reg};
                    state_next = ST_DIVK;
                end
            end
            ST_DIVK:
            begin
                if (drsp.done)
                begin
                    ck_next = drsp.quotient;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ok = !(mode_reg > tmss_pkg::MODE_OS || ph_reg > tmss_pkg::PH_5 ||
                       cm_reg == '0 ||
                       cn_reg == '0 || ck_reg == '0 || im_reg >= cm_reg ||
                       in_reg >= cn_reg || ik_reg >= ck_reg ||
                       (mode_reg == tmss_pkg::MODE_OS && ph_reg == tmss_pkg::PH_2));
                if (mode_reg == tmss_pkg::MODE_OS)
                begin
                    case (ph_reg)
                        tmss_pkg::PH_0: begin k = tmss_pkg::KIND_LOAD_INPUT; np = tmss_pkg::PH_1; end
                        tmss_pkg::PH_1: begin k = tmss_pkg::KIND_LOAD_WEIGHT; np = tmss_pkg::PH_3; end
                        tmss_pkg::PH_3: begin k = tmss_pkg::KIND_COMPUTE; np = tmss_pkg::PH_5; end
                        tmss_pkg::PH_5:
                        begin
                            k = tmss_pkg::KIND_SYNC;
                            if (ik_reg + 1'b1 < ck_reg)
                            begin
                                nk = ik_reg + 1'b1; np = tmss_pkg::PH_0;
                            end
                            else
                            begin
                                np = tmss_pkg::PH_4;
                            end
                        end
                        default:
                        begin
                            k = tmss_pkg::KIND_STORE_FINAL;
                            nk = '0;
                            inner_wrap = (in_reg + 1'b1 >= cn_reg);
                            outer_wrap = (im_reg + 1'b1 >= cm_reg);
                            if (!inner_wrap)
                            begin
                                nn = in_reg + 1'b1; np = tmss_pkg::PH_0;
                            end
                            else if (!outer_wrap)
                            begin
                                nn = '0; nm = im_reg + 1'b1; np = tmss_pkg::PH_0;
                            end
                            else
                            begin
                                nn = '0; nm = '0; np = tmss_pkg::PH_DONE;
                            end
                        end
                    endcase
                end
                else
                begin
                    case (ph_reg)
                        tmss_pkg::PH_0:
                        begin
                            k = (mode_reg == tmss_pkg::MODE_WS) ? tmss_pkg::KIND_LOAD_WEIGHT
                                                                : tmss_pkg::KIND_LOAD_INPUT;
                            np = tmss_pkg::PH_1;
                        end
                        tmss_pkg::PH_1:
                        begin
                            k = (mode_reg == tmss_pkg::MODE_WS) ? tmss_pkg::KIND_LOAD_INPUT
                                                                : tmss_pkg::KIND_LOAD_WEIGHT;
                            np = (ik_reg != '0) ? tmss_pkg::PH_2 : tmss_pkg::PH_3;
                        end
                        tmss_pkg::PH_2: begin k = tmss_pkg::KIND_RELOAD; np = tmss_pkg::PH_3; end
                        tmss_pkg::PH_3: begin k = tmss_pkg::KIND_COMPUTE; np = tmss_pkg::PH_4; end
                        tmss_pkg::PH_4:
                        begin
                            k = (ik_reg + 1'b1 < ck_reg) ? tmss_pkg::KIND_STORE_PART
                                                         : tmss_pkg::KIND_STORE_FINAL;
                            np = tmss_pkg::PH_5;
                        end
                        default:
                        begin
                            k = tmss_pkg::KIND_SYNC;
                            k_wrap = (ik_reg + 1'b1 >= ck_reg);
                            if (mode_reg == tmss_pkg::MODE_WS)
                            begin
                                inner_wrap = (im_reg + 1'b1 >= cm_reg);
                                outer_wrap = (in_reg + 1'b1 >= cn_reg);
                                if (!inner_wrap)
                                begin
                                    nm = im_reg + 1'b1; np = tmss_pkg::PH_1;
                                end
                                else
                                begin
                                    nm = '0;
                                    if (!k_wrap)
                                    begin
                                        nk = ik_reg + 1'b1; np = tmss_pkg::PH_0;
                                    end
                                    else if (!outer_wrap)
                                    begin
                                        nk = '0; nn = in_reg + 1'b1; np = tmss_pkg::PH_0;
                                    end
                                    else
                                    begin
                                        nk = '0; nn = '0; np = tmss_pkg::PH_DONE;
                                    end
                                end
                            end
                            else
                            begin
                                inner_wrap = (in_reg + 1'b1 >= cn_reg);
                                outer_wrap = (im_reg + 1'b1 >= cm_reg);
                                if (!inner_wrap)
                                begin
                                    nn = in_reg + 1'b1; np = tmss_pkg::PH_1;
                                end
                                else
                                begin
                                    nn = '0;
                                    if (!k_wrap)
                                    begin
                                        nk = ik_reg + 1'b1; np = tmss_pkg::PH_0;
                                    end
                                    else if (!outer_wrap)
                                    begin
                                        nk = '0; nm = im_reg + 1'b1; np = tmss_pkg::PH_0;
                                    end
                                    else
                                    begin
                                        nk = '0; nm = '0; np = tmss_pkg::PH_DONE;
                                    end
                                end
                            end
                        end
                    endcase
                end
                if (ok)
                begin
                    ok_next  = k;
                    om_next  = im_reg;
                    on_next  = in_reg;
                    okx_next = ik_reg;
                    fr_next  = (ik_reg + 1'b1 == ck_reg);
                    lst_next = (np == tmss_pkg::PH_DONE);
                    im_next = nm; in_next = nn; ik_next = nk; ph_next = np;
                    state_next = ST_EXTM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXTM:
            begin
                vm_next = ext;
                state_next = ST_EXTN;
            end
            ST_EXTN:
            begin
                vn_next = ext[11:0];
                state_next = ST_EXTK;
            end
            ST_EXTK:
            begin
                vk_next = ext;
                ov_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    op_next = op_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            lm_reg <= 24'd1; ln_reg <= 16'd1; lk_reg <= 24'd1;
            tm_reg <= 16'd1; tn_reg <= 12'd1; tk_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmss_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                tmss_pkg::REG_LM:   lm_reg   <= cfg_data[23:0];
                tmss_pkg::REG_LN:   ln_reg   <= cfg_data[15:0];
                tmss_pkg::REG_LK:   lk_reg   <= cfg_data[23:0];
                tmss_pkg::REG_TM:   tm_reg   <= cfg_data[15:0];
                tmss_pkg::REG_TN:   tn_reg   <= cfg_data[11:0];
                tmss_pkg::REG_TK:   tk_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control and schedule state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cm_reg <= '0; cn_reg <= '0; ck_reg <= '0;
            im_reg <= '0; in_reg <= '0; ik_reg <= '0;
            ph_reg <= tmss_pkg::PH_0; op_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cm_reg <= cm_next; cn_reg <= cn_next; ck_reg <= ck_next;
            im_reg <= im_next; in_reg <= in_next; ik_reg <= ik_next;
            ph_reg <= ph_next; op_reg <= op_next;
            ov_reg <= ov_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next; om_reg <= om_next; on_reg <= on_next; okx_reg <= okx_next;
        vm_reg <= vm_next; vn_reg <= vn_next; vk_reg <= vk_next;
        fr_reg <= fr_next; lst_reg <= lst_next;
    end

    assign out_valid       = ov_reg;
    assign kind            = ok_reg;
    assign m_index         = om_reg;
    assign n_index         = on_reg;
    assign k_index         = okx_reg;
    assign valid_m         = vm_reg;
    assign valid_n         = vn_reg;
    assign valid_k         = vk_reg;
    assign boundary        = (vm_reg < tm_reg) || (vn_reg < tn_reg) || (vk_reg < tk_reg);
    assign final_reduction = fr_reg;
    assign seq_number      = op_reg;
    assign last_op         = lst_reg;

endmodule

@@ hdl/tmss_checker.sv @@
// Port-level checker for the schedule sequencer, bound to the top level.
// Depends on assert_macros.svh and tmss_pkg.
`include "assert_macros.svh"
module tmss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [47:0] seq_number,
    input logic        last_op
);
    // A result waiting for its transaction keeps the block busy.
    `CHK_IMPLY(a_busy_out, clk, rst_n, out_valid, in_stall, "ready while result pending")
    // Kind never exceeds the sync code.
    `CHK_IMPLY(a_kind, clk, rst_n, out_valid, kind <= tmss_pkg::KIND_SYNC, "bad kind")
    // The final operation of a schedule is a sync or a final store.
    `CHK_IMPLY(a_last_kind, clk, rst_n, out_valid && last_op, kind == tmss_pkg::KIND_SYNC || kind == tmss_pkg::KIND_STORE_FINAL, "bad last operation")
    // A stalled result stays valid and holds its sequence number.
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(seq_number) && out_valid,
              "stalled result changed")
    // After a completed output transaction the block returns ready.
    `CHK_NEXT(a_free, clk, rst_n, out_valid && !out_stall, !out_valid && !in_stall,
              "not ready after output")
endmodule

bind tiled_matmul_schedule_sequencer tmss_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .seq_number(seq_number), .last_op(last_op)
);

@@ tb/sv/tiled_matmul_schedule_sequencer_tb.sv @@
// Self-checking testbench for the tiled matrix-product schedule sequencer.
// Depends on tmss_pkg and the tiled_matmul_schedule_sequencer RTL only.
// A scoreboard class predicts each operation and checks the output stream.
module tiled_matmul_schedule_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int M_W   = tmss_pkg::M_W;
    localparam int N_W   = tmss_pkg::N_W;
    localparam int K_W   = tmss_pkg::K_W;
    localparam int TM_W  = tmss_pkg::TM_W;
    localparam int TN_W  = tmss_pkg::TN_W;
    localparam int TK_W  = tmss_pkg::TK_W;
    localparam int SEQ_W = tmss_pkg::SEQ_W;
    localparam int CFG_W = tmss_pkg::CFG_W;
    localparam int IDX_W = tmss_pkg::IDX_W;

    // Expected contents of one output transaction.
    typedef struct packed {
        tmss_pkg::kind_t  kind;
        logic [M_W-1:0]   m_index;
        logic [N_W-1:0]   n_index;
        logic [K_W-1:0]   k_index;
        logic [TM_W-1:0]  valid_m;
        logic [TN_W-1:0]  valid_n;
        logic [TK_W-1:0]  valid_k;
        logic             boundary;
        logic             final_reduction;
        logic [SEQ_W-1:0] seq_number;
        logic             last_op;
    } sched_op_t;

    // Schedule predictor plus the queue of operations still owed by the block.
    class schedule_scoreboard;
        logic [1:0]  mode;
        logic [63:0] lm, ln, lk, tm, tn, tk;
        logic [63:0] cnt_m, cnt_n, cnt_k, im, in_, ik;
        logic [2:0]  ph;
        logic [SEQ_W-1:0] seq;
        sched_op_t   owed_ops[$];
        int          mismatches, results, requests, restarts;

        function new();
            mode = tmss_pkg::MODE_WS;
            lm = 1; ln = 1; lk = 1; tm = 1; tn = 1; tk = 1;
            cnt_m = 0; cnt_n = 0; cnt_k = 0; im = 0; in_ = 0; ik = 0;
            ph = tmss_pkg::PH_0; seq = 0;
            mismatches = 0; results = 0; requests = 0; restarts = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                tmss_pkg::REG_MODE: mode = val[1:0];
                tmss_pkg::REG_LM:   lm = 64'(val[23:0]);
                tmss_pkg::REG_LN:   ln = 64'(val[15:0]);
                tmss_pkg::REG_LK:   lk = 64'(val[23:0]);
                tmss_pkg::REG_TM:   tm = 64'(val[15:0]);
                tmss_pkg::REG_TN:   tn = 64'(val[11:0]);
                tmss_pkg::REG_TK:   tk = 64'(val[15:0]);
                default: ;
            endcase
        endfunction

        function logic [63:0] tiles(logic [63:0] size, logic [63:0] tile);
            if (tile == 0)
                return 0;
            return (size + tile - 1) / tile;
        endfunction

        function logic [63:0] span(logic [63:0] idx, logic [63:0] tile, logic [63:0] size);
            logic [63:0] off;
            off = idx * tile;
            if (off >= size)
                return 0;
            return (size - off < tile) ? size - off : tile;
        endfunction

        function void queue_op(tmss_pkg::kind_t k);
            sched_op_t op;
            logic [63:0] vm, vn, vk;
            vm = span(im, tm, lm);
            vn = span(in_, tn, ln);
            vk = span(ik, tk, lk);
            op.kind = k;
            op.m_index = im[M_W-1:0];
            op.n_index = in_[N_W-1:0];
            op.k_index = ik[K_W-1:0];
            op.valid_m = vm[TM_W-1:0];
            op.valid_n = vn[TN_W-1:0];
            op.valid_k = vk[TK_W-1:0];
            op.boundary = (vm < tm) || (vn < tn) || (vk < tk);
            op.final_reduction = (ik + 1 == cnt_k);
            op.seq_number = seq;
            op.last_op = 1'b0;
            seq = seq + 1'b1;
            owed_ops = {owed_ops, op};
        endfunction

        // Step the middle loop, carry into the outer one; 0 when both wrap.
        function bit advance(inout logic [63:0] mid, input logic [63:0] cmid,
                             inout logic [63:0] outer, input logic [63:0] couter);
            mid = mid + 1;
            if (mid < cmid)
                return 1;
            mid = 0;
            outer = outer + 1;
            if (outer < couter)
                return 1;
            outer = 0;
            return 0;
        endfunction

        // Note one accepted request and queue the operation it produces.
        function void note_request(logic rs);
            logic [63:0] inner_i, outer_i, c_inner, c_outer;
            bit more;
            requests++;
            if (rs)
            begin
                restarts++;
                cnt_m = tiles(lm, tm);
                cnt_n = tiles(ln, tn);
                cnt_k = tiles(lk, tk);
                im = 0; in_ = 0; ik = 0;
                ph = tmss_pkg::PH_0;
                seq = 0;
            end
            if (mode > tmss_pkg::MODE_OS || ph > tmss_pkg::PH_5 || cnt_m == 0 || cnt_n == 0 ||
                cnt_k == 0 || im >= cnt_m || in_ >= cnt_n || ik >= cnt_k ||
                (mode == tmss_pkg::MODE_OS && ph == tmss_pkg::PH_2))
                return;
            if (mode == tmss_pkg::MODE_OS)
            begin
                case (ph)
                    tmss_pkg::PH_0:
                    begin
                        queue_op(tmss_pkg::KIND_LOAD_INPUT);
                        ph = tmss_pkg::PH_1;
                    end
                    tmss_pkg::PH_1:
                    begin
                        queue_op(tmss_pkg::KIND_LOAD_WEIGHT);
                        ph = tmss_pkg::PH_3;
                    end
                    tmss_pkg::PH_3:
                    begin
                        queue_op(tmss_pkg::KIND_COMPUTE);
                        ph = tmss_pkg::PH_5;
                    end
                    tmss_pkg::PH_5:
                    begin
                        queue_op(tmss_pkg::KIND_SYNC);
                        if (ik + 1 < cnt_k)
                        begin
                            ik = ik + 1;
                            ph = tmss_pkg::PH_0;
                        end
                        else
                            ph = tmss_pkg::PH_4;
                    end
                    default:
                    begin
                        // Final store closes the reduction for this output tile.
                        queue_op(tmss_pkg::KIND_STORE_FINAL);
                        ik = 0;
                        more = advance(in_, cnt_n, im, cnt_m);
                        ph = more ? tmss_pkg::PH_0 : tmss_pkg::PH_DONE;
                    end
                endcase
            end
            else
            begin
                case (ph)
                    tmss_pkg::PH_0:
                    begin
                        queue_op(mode == tmss_pkg::MODE_WS ? tmss_pkg::KIND_LOAD_WEIGHT
                                                           : tmss_pkg::KIND_LOAD_INPUT);
                        ph = tmss_pkg::PH_1;
                    end
                    tmss_pkg::PH_1:
                    begin
                        queue_op(mode == tmss_pkg::MODE_WS ? tmss_pkg::KIND_LOAD_INPUT
                                                           : tmss_pkg::KIND_LOAD_WEIGHT);
                        ph = (ik > 0) ? tmss_pkg::PH_2 : tmss_pkg::PH_3;
                    end
                    tmss_pkg::PH_2:
                    begin
                        queue_op(tmss_pkg::KIND_RELOAD);
                        ph = tmss_pkg::PH_3;
                    end
                    tmss_pkg::PH_3:
                    begin
                        queue_op(tmss_pkg::KIND_COMPUTE);
                        ph = tmss_pkg::PH_4;
                    end
                    tmss_pkg::PH_4:
                    begin
                        queue_op((ik + 1 < cnt_k) ? tmss_pkg::KIND_STORE_PART
                                                  : tmss_pkg::KIND_STORE_FINAL);
                        ph = tmss_pkg::PH_5;
                    end
                    default:
                    begin
                        // Weight stationary runs M innermost, input stationary N.
                        queue_op(tmss_pkg::KIND_SYNC);
                        inner_i = (mode == tmss_pkg::MODE_WS) ? im : in_;
                        outer_i = (mode == tmss_pkg::MODE_WS) ? in_ : im;
                        c_inner = (mode == tmss_pkg::MODE_WS) ? cnt_m : cnt_n;
                        c_outer = (mode == tmss_pkg::MODE_WS) ? cnt_n : cnt_m;
                        inner_i = inner_i + 1;
                        if (inner_i < c_inner)
                            ph = tmss_pkg::PH_1;
                        else
                        begin
                            inner_i = 0;
                            more = advance(ik, cnt_k, outer_i, c_outer);
                            ph = more ? tmss_pkg::PH_0 : tmss_pkg::PH_DONE;
                        end
                        if (mode == tmss_pkg::MODE_WS)
                        begin
                            im = inner_i;
                            in_ = outer_i;
                        end
                        else
                        begin
                            in_ = inner_i;
                            im = outer_i;
                        end
                    end
                endcase
            end
            owed_ops[$].last_op = (ph == tmss_pkg::PH_DONE);
        endfunction

        // Compare one accepted result against the oldest owed operation.
        function void check_result(sched_op_t got);
            sched_op_t want;
            results++;
            if (owed_ops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected operation: %p", got);
                return;
            end
            want = owed_ops.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch:\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic             restart;
    logic             out_valid;
    logic             out_stall;
    logic [2:0]       kind;
    logic [M_W-1:0]   m_index;
    logic [N_W-1:0]   n_index;
    logic [K_W-1:0]   k_index;
    logic [TM_W-1:0]  valid_m;
    logic [TN_W-1:0]  valid_n;
    logic [TK_W-1:0]  valid_k;
    logic             boundary;
    logic             final_reduction;
    logic [SEQ_W-1:0] seq_number;
    logic             last_op;

    schedule_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    tiled_matmul_schedule_sequencer dut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver stalls at random.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Observe both handshakes at the clock edge.
    always @(posedge clk)
    begin
        sched_op_t got;
        if (rst_n && in_valid && !in_stall)
            sb.note_request(restart);
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = tmss_pkg::kind_t'(kind);
            got.m_index = m_index;
            got.n_index = n_index;
            got.k_index = k_index;
            got.valid_m = valid_m;
            got.valid_n = valid_n;
            got.valid_k = valid_k;
            got.boundary = boundary;
            got.final_reduction = final_reduction;
            got.seq_number = seq_number;
            got.last_op = last_op;
            sb.check_result(got);
        end
    end

    // Send one request transaction, with random idle cycles ahead of it.
    task automatic send_request(logic rs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Let the block go quiet: all owed operations out, then its own latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed_ops.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Write all seven registers back to back while the block is idle.
    task automatic load_config(logic [CFG_W-1:0] vals[7]);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data <= vals[i];
            sb.write_reg(IDX_W'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // One configuration phase: settings, then a burst of requests.
    task automatic run_phase(logic [CFG_W-1:0] vals[7], int count, bit first_restart,
                             int restart_pct);
        load_config(vals);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                send_request(first_restart);
            else
                send_request($urandom_range(99) < restart_pct);
        end
        drain();
    endtask

    function automatic logic [CFG_W-1:0] pick_size(int maxv, int full);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 8)
            return CFG_W'(full);
        return CFG_W'($urandom_range(maxv, 1));
    endfunction

    initial
    begin
        logic [CFG_W-1:0] v[7];
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        restart = 1'b0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests before any restart produce nothing.
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // Directed: each dataflow, ragged edges, then mode three and a zero tile.
        v = '{CFG_W'(tmss_pkg::MODE_WS), 3, 3, 3, 2, 2, 2};
        run_phase(v, 6, 1'b1, 0);
        v = '{CFG_W'(tmss_pkg::MODE_IS), 3, 3, 3, 2, 2, 2};
        run_phase(v, 4, 1'b1, 0);
        v = '{CFG_W'(tmss_pkg::MODE_OS), 2, 1, 3, 2, 1, 2};
        run_phase(v, 4, 1'b1, 0);
        v = '{CFG_W'(3), 3, 3, 3, 2, 2, 2};
        run_phase(v, 2, 1'b1, 0);
        v = '{CFG_W'(tmss_pkg::MODE_WS), 3, 3, 3, 0, 2, 2};
        run_phase(v, 2, 1'b1, 0);
        // Largest sizes and tiles, then tiles bigger than the problem.
        v = '{CFG_W'(tmss_pkg::MODE_OS), 24'hFFFFFF, 24'h00FFFF, 24'hFFFFFF, 24'h00FFFF,
              24'h000FFF, 24'h00FFFF};
        run_phase(v, 4, 1'b1, 0);
        v = '{CFG_W'(tmss_pkg::MODE_WS), 1, 1, 1, 24'h00FFFF, 24'h000FFF, 24'h00FFFF};
        run_phase(v, 3, 1'b1, 0);

        // Random phases; about one in five continues the old schedule.
        for (int third = 0; third < 3; third++)
        begin
            send_idle_pct = (third == 0) ? 23 : (third == 1) ? 79 : 0;
            recv_stall_pct = (third == 0) ? 79 : (third == 1) ? 23 : 0;
            while (sb.requests < 25 + (third + 1) * 660)
            begin
                v[0] = ($urandom_range(19) == 0) ? CFG_W'(3) : CFG_W'($urandom_range(2));
                v[1] = pick_size(40, 24'hFFFFFF);
                v[2] = pick_size(40, 24'h00FFFF);
                v[3] = pick_size(40, 24'hFFFFFF);
                v[4] = pick_size(12, 24'h00FFFF);
                v[5] = pick_size(12, 24'h000FFF);
                v[6] = pick_size(12, 24'h00FFFF);
                run_phase(v, $urandom_range(120, 20), $urandom_range(99) < 80, 2);
            end
        end

        $display("Ran %0d requests with %0d restarts over all three dataflows and %0d checked",
                 sb.requests, sb.restarts, sb.results);
        $display("operations, including ragged, oversized, zero and unused-mode settings.");
        if (sb.mismatches == 0 && sb.owed_ops.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d operations never produced", sb.mismatches,
                     sb.owed_ops.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run-time limit.
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tmss_pkg.sv
hdl/tmss_ceil_div.sv
hdl/tiled_matmul_schedule_sequencer.sv
hdl/tmss_checker.sv
tb/sv/tiled_matmul_schedule_sequencer_tb.sv
